// File: hdl/smbe_pkg.sv
// Shared types and constants for the SPI mode 0 byte engine.
`timescale 1ns / 1ps

package smbe_pkg;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = 2;
    localparam int CMD_CNT_W = 3;
    localparam int RES_DEPTH = 2;
    localparam int RES_PTR_W = 1;
    localparam int RES_CNT_W = 2;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;

    localparam logic [7:0] BYTE_MSB   = 8'h80;
    localparam logic [7:0] BYTE_LSB   = 8'h01;
    localparam logic [7:0] RX_INIT    = 8'hFF;
    localparam logic [7:0] HALF_INIT  = 8'd1;
    localparam logic [7:0] TICK_MAX   = 8'hFF;
    localparam logic [3:0] BITS_BYTE  = 4'd8;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_HALF_PERIOD = 1'b0;

    // One classified request on its way from the front to the engine.
    typedef struct packed {
        logic       is_start;
        logic       do_write;
        logic       do_read;
        logic [7:0] tx_byte;
        logic       assert_cs;
        logic       release_cs;
        logic       miso;
    } cmd_t;

    // One result: pin levels and status after a request.
    typedef struct packed {
        logic       sck;
        logic       mosi;
        logic       cs_n;
        logic       busy;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       start_rejected;
    } res_t;

endpackage

// File: hdl/smbe_front.sv
// Front end: takes requests, classifies them and holds them in a short queue.
`timescale 1ns / 1ps

module smbe_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic             opcode,
    input  logic [1:0]       transfer_kind,
    input  logic [7:0]       tx_byte,
    input  logic             assert_cs,
    input  logic             release_cs,
    input  logic             miso,
    output logic             cmd_valid,
    output smbe_pkg::cmd_t   cmd,
    input  logic             cmd_take
);
    import smbe_pkg::*;

    cmd_t                 queue_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_CNT_W-1:0] count_reg;
    logic [CMD_CNT_W-1:0] count_next;
    logic                 accept;
    cmd_t                 classified;

    assign full      = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign accept    = push && !full;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];

    // Kind three behaves as write and read, which the two flags give directly.
    always_comb
    begin
        classified.is_start   = (opcode == OP_START);
        classified.do_write   = (transfer_kind != KIND_READ);
        classified.do_read    = (transfer_kind != KIND_WRITE);
        classified.tx_byte    = tx_byte;
        classified.assert_cs  = assert_cs;
        classified.release_cs = release_cs;
        classified.miso       = miso;
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept && !cmd_take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!accept && cmd_take)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            queue_reg[wr_ptr_reg] <= classified;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (cmd_take)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: hdl/smbe_engine.sv
// Back end: SPI bit timing and shifting, plus the result queue.
`timescale 1ns / 1ps

module smbe_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       half_period,
    input  logic             cmd_valid,
    input  smbe_pkg::cmd_t   cmd,
    output logic             cmd_take,
    output logic             empty,
    input  logic             pop,
    output smbe_pkg::res_t   res
);
    import smbe_pkg::*;

    logic       sck_reg,         sck_next;
    logic       mosi_reg,        mosi_next;
    logic       cs_reg,          cs_next;
    logic       active_reg,      active_next;
    logic       wr_reg,          wr_next;
    logic       rd_reg,          rd_next;
    logic [7:0] tx_shift_reg,    tx_shift_next;
    logic [7:0] rx_shift_reg,    rx_shift_next;
    logic [3:0] bits_left_reg,   bits_left_next;
    logic       second_half_reg, second_half_next;
    logic [7:0] tick_count_reg,  tick_count_next;
    logic       release_reg,     release_next;

    logic [7:0] limit;
    logic [8:0] tick_inc;
    logic       half_done;
    logic [3:0] bits_dec;
    logic [7:0] rx_sampled;
    res_t       res_next;

    res_t                 res_q_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] res_wr_reg;
    logic [RES_PTR_W-1:0] res_rd_reg;
    logic [RES_CNT_W-1:0] res_count_reg;
    logic [RES_CNT_W-1:0] res_count_next;
    logic                 res_pop;

    assign res_pop  = pop && !empty;
    assign empty    = (res_count_reg == '0);
    assign res      = res_q_reg[res_rd_reg];
    assign cmd_take = cmd_valid && (res_count_reg != RES_CNT_W'(RES_DEPTH));

    assign limit      = (half_period == 8'd0) ? HALF_INIT : half_period;
    assign tick_inc   = {1'b0, tick_count_reg} + 9'd1;
    assign half_done  = (tick_count_reg == TICK_MAX) || (tick_inc >= {1'b0, limit});
    assign bits_dec   = bits_left_reg - 1'b1;
    assign rx_sampled = {rx_shift_reg[6:0], 1'b0} | (cmd.miso ? BYTE_LSB : 8'h00);

    always_comb
    begin
        sck_next         = sck_reg;
        mosi_next        = mosi_reg;
        cs_next          = cs_reg;
        active_next      = active_reg;
        wr_next          = wr_reg;
        rd_next          = rd_reg;
        tx_shift_next    = tx_shift_reg;
        rx_shift_next    = rx_shift_reg;
        bits_left_next   = bits_left_reg;
        second_half_next = second_half_reg;
        tick_count_next  = tick_count_reg;
        release_next     = release_reg;
        res_next.rx_valid       = 1'b0;
        res_next.rx_byte        = 8'h00;
        res_next.start_rejected = 1'b0;

        if (cmd.is_start)
        begin
            if (active_reg)
            begin
                res_next.start_rejected = 1'b1;
            end
            else
            begin
                if (cmd.assert_cs)
                begin
                    cs_next = 1'b0;
                end
                wr_next          = cmd.do_write;
                rd_next          = cmd.do_read;
                release_next     = cmd.release_cs;
                rx_shift_next    = RX_INIT;
                bits_left_next   = BITS_BYTE;
                active_next      = 1'b1;
                sck_next         = 1'b0;
                second_half_next = 1'b0;
                tick_count_next  = 8'd0;
                tx_shift_next    = cmd.tx_byte;
                if (cmd.do_write)
                begin
                    mosi_next     = ((cmd.tx_byte & BYTE_MSB) != 8'h00);
                    tx_shift_next = {cmd.tx_byte[6:0], 1'b0};
                end
            end
        end
        else if (active_reg)
        begin
            if (!half_done)
            begin
                tick_count_next = tick_inc[7:0];
            end
            else if (!second_half_reg)
            begin
                sck_next         = 1'b1;
                second_half_next = 1'b1;
                tick_count_next  = 8'd0;
            end
            else
            begin
                // End of a bit: sample MISO, then start the next bit or finish.
                rx_shift_next    = rx_sampled;
                bits_left_next   = bits_dec;
                sck_next         = 1'b0;
                second_half_next = 1'b0;
                tick_count_next  = 8'd0;
                if (bits_dec != 4'd0)
                begin
                    if (wr_reg)
                    begin
                        mosi_next     = ((tx_shift_reg & BYTE_MSB) != 8'h00);
                        tx_shift_next = {tx_shift_reg[6:0], 1'b0};
                    end
                end
                else
                begin
                    active_next  = 1'b0;
                    release_next = 1'b0;
                    if (release_reg)
                    begin
                        cs_next = 1'b1;
                    end
                    if (rd_reg)
                    begin
                        res_next.rx_valid = 1'b1;
                        res_next.rx_byte  = rx_sampled;
                    end
                end
            end
        end

        res_next.sck  = sck_next;
        res_next.mosi = mosi_next;
        res_next.cs_n = cs_next;
        res_next.busy = active_next;
    end

    always_comb
    begin
        res_count_next = res_count_reg;
        if (cmd_take && !res_pop)
        begin
            res_count_next = res_count_reg + 1'b1;
        end
        else if (!cmd_take && res_pop)
        begin
            res_count_next = res_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            res_q_reg[res_wr_reg] <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sck_reg         <= 1'b0;
            mosi_reg        <= 1'b0;
            cs_reg          <= 1'b1;
            active_reg      <= 1'b0;
            wr_reg          <= 1'b1;
            rd_reg          <= 1'b0;
            tx_shift_reg    <= 8'h00;
            rx_shift_reg    <= RX_INIT;
            bits_left_reg   <= 4'd0;
            second_half_reg <= 1'b0;
            tick_count_reg  <= 8'd0;
            release_reg     <= 1'b0;
            res_wr_reg      <= '0;
            res_rd_reg      <= '0;
            res_count_reg   <= '0;
        end
        else
        begin
            if (cmd_take)
            begin
                sck_reg         <= sck_next;
                mosi_reg        <= mosi_next;
                cs_reg          <= cs_next;
                active_reg      <= active_next;
                wr_reg          <= wr_next;
                rd_reg          <= rd_next;
                tx_shift_reg    <= tx_shift_next;
                rx_shift_reg    <= rx_shift_next;
                bits_left_reg   <= bits_left_next;
                second_half_reg <= second_half_next;
                tick_count_reg  <= tick_count_next;
                release_reg     <= release_next;
                res_wr_reg      <= res_wr_reg + 1'b1;
            end
            if (res_pop)
            begin
                res_rd_reg <= res_rd_reg + 1'b1;
            end
            res_count_reg <= res_count_next;
        end
    end

endmodule

// File: hdl/spi_master_byte_engine.sv
// Top level of the SPI mode 0 byte engine: register port, front, engine, checks.
//
//   Channel   Dir  Handshake               Carries
//   request   in   push / full             opcode, transfer_kind, tx_byte, assert_cs,
//                                          release_cs, miso
//   result    out  empty / pop             sck, mosi, cs_n, busy_res, rx_valid, rx_byte,
//                                          start_rejected
//   config    in   psel/penable/pwrite     half_period_ticks at byte address 0
//
// One request is taken every clock while one waits and the result queue has room;
// the engine updates its SPI state as it takes each request and writes the result
// into the result queue, from which it can be popped.
// Reset leaves chip select high, SCK and MOSI low, and the half period at one tick.
// A stalled result side fills the two-entry result queue, then the four-entry
// request queue, and only then raises full.
`timescale 1ns / 1ps

module spi_master_byte_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [smbe_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [smbe_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [smbe_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              push,
    output logic                              full,
    input  logic                              opcode,
    input  logic [1:0]                        transfer_kind,
    input  logic [7:0]                        tx_byte,
    input  logic                              assert_cs,
    input  logic                              release_cs,
    input  logic                              miso,
    output logic                              empty,
    input  logic                              pop,
    output logic                              sck,
    output logic                              mosi,
    output logic                              cs_n,
    output logic                              busy_res,
    output logic                              rx_valid,
    output logic [7:0]                        rx_byte,
    output logic                              start_rejected
);
    import smbe_pkg::*;

    logic [7:0] half_period_reg;
    logic       reg_index;
    logic       cfg_write;
    logic       cmd_valid;
    logic       cmd_take;
    cmd_t       cmd;
    res_t       res;

    // Registers sit on 4-byte boundaries; the low address bits are ignored.
    assign reg_index = paddr[APB_ADDR_W-1];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (reg_index == REG_HALF_PERIOD)
                     ? {{(APB_DATA_W-8){1'b0}}, half_period_reg}
                     : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_INIT;
        end
        else if (cfg_write && (reg_index == REG_HALF_PERIOD))
        begin
            half_period_reg <= pwdata[7:0];
        end
    end

    smbe_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .transfer_kind (transfer_kind),
        .tx_byte       (tx_byte),
        .assert_cs     (assert_cs),
        .release_cs    (release_cs),
        .miso          (miso),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_take      (cmd_take)
    );

    smbe_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .half_period (half_period_reg),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_take    (cmd_take),
        .empty       (empty),
        .pop         (pop),
        .res         (res)
    );

    assign sck            = res.sck;
    assign mosi           = res.mosi;
    assign cs_n           = res.cs_n;
    assign busy_res       = res.busy;
    assign rx_valid       = res.rx_valid;
    assign rx_byte        = res.rx_byte;
    assign start_rejected = res.start_rejected;

    // A finished read byte always ends the transfer.
    a_rx_ends_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rx_valid) |-> !busy_res)
        else $error("received byte reported while still busy");

    // A start is only turned away while a transfer is running, and that transfer goes on.
    a_reject_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && start_rejected) |-> (busy_res && !rx_valid))
        else $error("start rejected while idle");

    // The received byte reads as zero unless a read just finished.
    a_rx_byte_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !rx_valid) |-> (rx_byte == 8'h00))
        else $error("received byte not cleared");

    // The engine never takes a request when the front queue is empty.
    a_take_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid)
        else $error("engine took a request from an empty queue");

endmodule

// File: test/tb_spi_master_byte_engine.sv
// Self-checking testbench for the SPI mode 0 byte engine, checked against a pin-level predictor.
`timescale 1ns / 1ps

module tb_spi_master_byte_engine;
    import smbe_pkg::*;

    localparam logic [1:0] KIND_BOTH  = 2'd2;
    localparam logic [1:0] KIND_THREE = 2'd3;
    localparam int REG_UNUSED = 1;
    localparam logic [APB_ADDR_W-1:0] ADDR_HALF   = {REG_HALF_PERIOD, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED = APB_ADDR_W'(REG_UNUSED * 4);
    localparam int DIR_ROWS   = 6;
    localparam int NUM_PHASES = 11;

    typedef struct packed {
        logic       op;
        logic [1:0] kind;
        logic [7:0] txb;
        logic       acs;
        logic       rcs;
        logic       miso_lvl;
    } spi_req_t;

    typedef struct packed {
        spi_req_t   req;
        logic [4:0] reps;
        logic       fixed;
        res_t       pins;
    } dir_row_t;

    typedef enum logic [1:0] {POP_ALWAYS, POP_HALF, POP_THIRD, POP_MOSTLY} stall_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  push;
    logic                  full;
    logic                  opcode;
    logic [1:0]            transfer_kind;
    logic [7:0]            tx_byte;
    logic                  assert_cs;
    logic                  release_cs;
    logic                  miso;
    logic                  empty;
    logic                  pop;
    logic                  sck;
    logic                  mosi;
    logic                  cs_n;
    logic                  busy_res;
    logic                  rx_valid;
    logic [7:0]            rx_byte;
    logic                  start_rejected;

    spi_master_byte_engine u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .push           (push),
        .full           (full),
        .opcode         (opcode),
        .transfer_kind  (transfer_kind),
        .tx_byte        (tx_byte),
        .assert_cs      (assert_cs),
        .release_cs     (release_cs),
        .miso           (miso),
        .empty          (empty),
        .pop            (pop),
        .sck            (sck),
        .mosi           (mosi),
        .cs_n           (cs_n),
        .busy_res       (busy_res),
        .rx_valid       (rx_valid),
        .rx_byte        (rx_byte),
        .start_rejected (start_rejected)
    );

    // Predicted SPI engine state and configuration.
    logic [7:0] half_cfg  = HALF_INIT;
    logic       p_sck     = 1'b0;
    logic       p_mosi    = 1'b0;
    logic       p_cs      = 1'b1;
    logic       p_active  = 1'b0;
    logic [1:0] p_kind    = KIND_WRITE;
    logic [7:0] p_tx      = 8'h00;
    logic [7:0] p_rx      = RX_INIT;
    logic [3:0] p_bits    = 4'd0;
    logic       p_second  = 1'b0;
    logic [7:0] p_ticks   = 8'd0;
    logic       p_release = 1'b0;

    res_t pin_expect_q [$];
    int   err_cnt     = 0;
    int   checked_cnt = 0;
    int   sent_cnt    = 0;
    int   rx_seen     = 0;
    int   rej_seen    = 0;
    int   cfg_writes  = 0;
    int   burst_left  = 0;

    dir_row_t   dir_table [DIR_ROWS];
    logic [7:0] phase_half [NUM_PHASES];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_spi_master_byte_engine: done, errors");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        $display("ERROR: %s", msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            flag_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                    checked_cnt, name, got, want));
    endtask

    // First half of a bit: SCK low, and MOSI takes the next bit unless the byte is read only.
    function automatic void start_bit();
        p_sck = 1'b0;
        if (p_kind != KIND_READ)
        begin
            p_mosi = ((p_tx & BYTE_MSB) != 8'h00);
            p_tx   = p_tx << 1;
        end
        p_second = 1'b0;
        p_ticks  = 8'd0;
    endfunction

    function automatic res_t predict_pins(input spi_req_t r);
        res_t       o;
        logic [7:0] lim;
        logic [7:0] nxt;
        o   = '0;
        lim = (half_cfg == 8'd0) ? 8'd1 : half_cfg;
        if (r.op == OP_START)
        begin
            if (p_active)
            begin
                o.start_rejected = 1'b1;
            end
            else
            begin
                if (r.acs)
                    p_cs = 1'b0;
                p_kind    = r.kind;
                p_release = r.rcs;
                p_tx      = r.txb;
                p_rx      = RX_INIT;
                p_bits    = BITS_BYTE;
                p_active  = 1'b1;
                start_bit();
            end
        end
        else if (p_active)
        begin
            nxt = p_ticks + 8'd1;
            // A half period shortened mid-count ends on the very next tick.
            if (p_ticks == TICK_MAX || nxt >= lim)
            begin
                if (!p_second)
                begin
                    p_sck    = 1'b1;
                    p_second = 1'b1;
                    p_ticks  = 8'd0;
                end
                else
                begin
                    p_rx   = {p_rx[6:0], r.miso_lvl};
                    p_bits = p_bits - 4'd1;
                    if (p_bits != 4'd0)
                    begin
                        start_bit();
                    end
                    else
                    begin
                        p_sck    = 1'b0;
                        p_second = 1'b0;
                        p_ticks  = 8'd0;
                        p_active = 1'b0;
                        if (p_release)
                            p_cs = 1'b1;
                        p_release = 1'b0;
                        if (p_kind != KIND_WRITE)
                        begin
                            o.rx_valid = 1'b1;
                            o.rx_byte  = p_rx;
                        end
                    end
                end
            end
            else
            begin
                p_ticks = nxt;
            end
        end
        o.sck  = p_sck;
        o.mosi = p_mosi;
        o.cs_n = p_cs;
        o.busy = p_active;
        return o;
    endfunction

    function automatic dir_row_t dir_row(input logic op, input logic [1:0] kind,
                                         input logic [7:0] txb, input logic acs,
                                         input logic rcs, input logic ml, input int reps,
                                         input logic fixed, input logic e_sck,
                                         input logic e_mosi, input logic e_cs,
                                         input logic e_busy, input logic e_rej);
        dir_row_t d;
        d.req   = '{op, kind, txb, acs, rcs, ml};
        d.reps  = 5'(reps);
        d.fixed = fixed;
        d.pins  = '{e_sck, e_mosi, e_cs, e_busy, 1'b0, 8'h00, e_rej};
        return d;
    endfunction

    // Offers one request in bursts with random gaps, and records its expected pins.
    task automatic send_request(input spi_req_t r, input logic fixed, input res_t pins);
        res_t want;
        int   gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        push          <= 1'b1;
        opcode        <= r.op;
        transfer_kind <= r.kind;
        tx_byte       <= r.txb;
        assert_cs     <= r.acs;
        release_cs    <= r.rcs;
        miso          <= r.miso_lvl;
        @(posedge clk);
        while (full) @(posedge clk);
        want = predict_pins(r);
        pin_expect_q.push_back(fixed ? pins : want);
        sent_cnt++;
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pin_expect_q.size() != 0) @(posedge clk);
    endtask

    // Register write, then a read back of the half period to confirm what took effect.
    task automatic set_half_period(input logic [APB_ADDR_W-1:0] addr, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= APB_DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_HALF)
            half_cfg = val;
        cfg_writes++;
        @(posedge clk);
        psel    <= 1'b1;
        paddr   <= ADDR_HALF;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata[7:0] != half_cfg)
            flag_mismatch($sformatf("half period reads %0d, expected %0d",
                                    prdata[7:0], half_cfg));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : request_side
        spi_req_t r;
        int       n;
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        push          <= 1'b0;
        opcode        <= OP_TICK;
        transfer_kind <= KIND_WRITE;
        tx_byte       <= 8'h00;
        assert_cs     <= 1'b0;
        release_cs    <= 1'b0;
        miso          <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle tick, a full write byte with a start rejected on the way, then a
        // kind-three start that keeps chip select and a second rejected start.
        dir_table = '{
            dir_row(OP_TICK,  KIND_WRITE, 8'h00, 1'b0, 1'b0, 1'b1, 1,  1'b1,
                    1'b0, 1'b0, 1'b1, 1'b0, 1'b0),
            dir_row(OP_START, KIND_WRITE, 8'hFF, 1'b1, 1'b0, 1'b0, 1,  1'b1,
                    1'b0, 1'b1, 1'b0, 1'b1, 1'b0),
            dir_row(OP_START, KIND_BOTH,  8'h00, 1'b0, 1'b1, 1'b0, 1,  1'b1,
                    1'b0, 1'b1, 1'b0, 1'b1, 1'b1),
            dir_row(OP_TICK,  KIND_WRITE, 8'h00, 1'b0, 1'b0, 1'b1, 16, 1'b0,
                    1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
            dir_row(OP_START, KIND_THREE, 8'h00, 1'b0, 1'b1, 1'b0, 1,  1'b1,
                    1'b0, 1'b0, 1'b0, 1'b1, 1'b0),
            dir_row(OP_START, KIND_READ,  8'hFF, 1'b1, 1'b0, 1'b1, 1,  1'b1,
                    1'b0, 1'b0, 1'b0, 1'b1, 1'b1)
        };
        foreach (dir_table[i])
            repeat (dir_table[i].reps)
                send_request(dir_table[i].req, dir_table[i].fixed, dir_table[i].pins);

        phase_half = '{8'd2, 8'd0, 8'd255, 8'd1, 8'd5, 8'd3, 8'd8, 8'd2, 8'd1, 8'd4, 8'd6};
        phase_half[NUM_PHASES-1] = 8'($urandom_range(1, 16));
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_results();
            if (ph == 4)
                set_half_period(ADDR_UNUSED, 8'd77);
            set_half_period(ADDR_HALF, phase_half[ph]);
            n = (phase_half[ph] == 8'd255) ? 300 : 135;
            for (int k = 0; k < n; k++)
            begin
                r.kind     = 2'($urandom_range(0, 3));
                r.txb      = 8'($urandom_range(0, 255));
                r.acs      = 1'($urandom_range(0, 1));
                r.rcs      = 1'($urandom_range(0, 1));
                r.miso_lvl = 1'($urandom_range(0, 1));
                // Mostly complete bytes: start when idle, tick while busy, a little noise.
                if (p_active)
                    r.op = ($urandom_range(0, 31) == 0) ? OP_START : OP_TICK;
                else
                    r.op = ($urandom_range(0, 3) != 0) ? OP_START : OP_TICK;
                send_request(r, 1'b0, '0);
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (pin_expect_q.size() != 0)
            flag_mismatch($sformatf("%0d expected results never arrived", pin_expect_q.size()));
        $display("Run covered %0d requests under %0d register writes: %0d bytes read back,",
                 sent_cnt, cfg_writes, rx_seen);
        $display("%0d starts rejected while busy, with bursty input and a stalled result side.",
                 rej_seen);
        if (err_cnt == 0)
            $display("tb_spi_master_byte_engine: done, clean");
        else
            $display("tb_spi_master_byte_engine: done, errors");
        $finish;
    end

    initial
    begin : result_side
        int          cyc;
        int          hold_left;
        bit          hold_done;
        logic        nxt_pop;
        res_t        want;
        stall_mode_t mode;
        cyc       = 0;
        hold_left = 0;
        hold_done = 1'b0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (rst_n && pop && !empty)
            begin
                if (pin_expect_q.size() == 0)
                begin
                    flag_mismatch("result arrived with no request waiting");
                end
                else
                begin
                    want = pin_expect_q.pop_front();
                    check_field("sck", sck, want.sck);
                    check_field("mosi", mosi, want.mosi);
                    check_field("cs_n", cs_n, want.cs_n);
                    check_field("busy_res", busy_res, want.busy);
                    check_field("rx_valid", rx_valid, want.rx_valid);
                    check_field("rx_byte", rx_byte, want.rx_byte);
                    check_field("start_rejected", start_rejected, want.start_rejected);
                    if (want.rx_valid)
                        rx_seen++;
                    if (want.start_rejected)
                        rej_seen++;
                    checked_cnt++;
                end
            end
            // One long hold-off lets both queues fill so that full stalls the sender.
            if (!hold_done && checked_cnt >= 400)
            begin
                hold_left = 150;
                hold_done = 1'b1;
            end
            mode = stall_mode_t'((cyc / 97) % 4);
            if (hold_left > 0)
            begin
                hold_left--;
                nxt_pop = 1'b0;
            end
            else
            begin
                case (mode)
                    POP_ALWAYS: nxt_pop = 1'b1;
                    POP_HALF:   nxt_pop = 1'($urandom_range(0, 1));
                    POP_THIRD:  nxt_pop = (cyc % 3 == 0);
                    default:    nxt_pop = ($urandom_range(0, 7) != 0);
                endcase
            end
            pop <= nxt_pop;
        end
    end

endmodule

// File: spi_master_byte_engine.f
hdl/smbe_pkg.sv
hdl/smbe_front.sv
hdl/smbe_engine.sv
hdl/spi_master_byte_engine.sv
test/tb_spi_master_byte_engine.sv
